[rtl/lpac_pkg.sv]
package lpac_pkg;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_DETECT = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_SWEEP  = 2'd2,
        KIND_DUMP   = 2'd3
    } t_kind;

    // Result status codes
    localparam logic [2:0] ST_MATCHED    = 3'd0;
    localparam logic [2:0] ST_INSERTED   = 3'd1;
    localparam logic [2:0] ST_DROPPED    = 3'd2;
    localparam logic [2:0] ST_SWEEP_DONE = 3'd3;
    localparam logic [2:0] ST_DUMP_ENTRY = 3'd4;
    localparam logic [2:0] ST_DUMP_EMPTY = 3'd5;

    // Configuration register indexes
    localparam logic CFG_MATCH_RADIUS = 1'b0;
    localparam logic CFG_EXPIRY_TICKS = 1'b1;

    localparam int unsigned REG_RADIUS_RESET = 64;
    localparam int unsigned REG_EXPIRY_RESET = 50;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         label;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        entry_id;
        logic [7:0]         entry_label;
        logic signed [23:0] mean_x;
        logic signed [23:0] mean_y;
        logic signed [23:0] mean_z;
        logic [15:0]        hit_count;
        logic [6:0]         removed_count;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_WIN_RD,
        S_DIV_GO,
        S_DIV,
        S_UPD,
        S_INS,
        S_SWEEP,
        S_SWEEP_END,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_PREP,
        DIV_ITER
    } t_div_ph;

    typedef struct packed {
        logic busy;
        logic found;
    } t_scan_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/labeled_point_association_cache.sv]
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready o_out_data (t_out_item)
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Items are accepted only in the idle state. A detection scans the used entries, then reaches
// a match result through the window read and the shared restoring divider (one bit a cycle,
// three lanes), or goes straight to an insert or drop result. Tick: accept only. Sweep: scans
// the used entries, then emits its result. Dump: a memory read state and an output state per
// entry, or the output state alone for the empty result. Reset is synchronous, active low.
// A stalled output holds the emit state; once loaded, the output register frees the input.
module labeled_point_association_cache
    import lpac_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int COORD_WIDTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int UW = $clog2(CAPACITY + 1);
    localparam int CW = COORD_WIDTH;
    localparam int EW = 3 * CW + 88;

    localparam int OFS_Y   = CW;
    localparam int OFS_Z   = 2 * CW;
    localparam int OFS_LAB = 3 * CW;
    localparam int OFS_HIT = 3 * CW + 8;
    localparam int OFS_ID  = 3 * CW + 24;
    localparam int OFS_STP = 3 * CW + 56;

    t_state r_state, n_state;

    logic [UW-1:0]        r_used, r_idx, r_keep, r_removed;
    logic [31:0]          r_tick, r_next_id;
    logic [15:0]          r_radius, r_expiry;
    logic [7:0]           r_lab;
    logic signed [CW-1:0] r_px, r_py, r_pz;
    logic                 r_rd_v;
    logic [AW-1:0]        r_rd_idx;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic          w_accept, w_out_free, w_emit, w_expired, w_last_dump;
    t_out_item     w_emit_data;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr, w_win;
    logic [EW-1:0] w_wdata, w_rdata;
    logic [15:0]   w_hits, w_hits_new;
    logic [31:0]   w_age;
    t_scan_stat    w_scan;
    t_div_stat     w_div;
    logic signed [CW-1:0] w_qx, w_qy, w_qz;

    function automatic logic [CW-1:0] f_sat(input logic signed [23:0] v);
        logic signed [32:0] e, hi, lo;
        e  = 33'(v);
        hi = (33'sd1 <<< (CW - 1)) - 33'sd1;
        lo = -hi - 33'sd1;
        if (e > hi) e = hi;
        else if (e < lo) e = lo;
        return e[CW-1:0];
    endfunction

    function automatic logic [23:0] f_out24(input logic signed [CW-1:0] v);
        logic signed [32:0] e;
        e = 33'(v);
        return e[23:0];
    endfunction

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_hits      = w_rdata[OFS_HIT+15:OFS_HIT];
    assign w_hits_new  = (w_hits == 16'hFFFF) ? w_hits : w_hits + 16'd1;
    assign w_age       = r_tick - w_rdata[OFS_STP+31:OFS_STP];
    assign w_expired   = w_age > {16'd0, r_expiry};
    assign w_last_dump = (r_idx + UW'(1)) == r_used;

    lpac_mem #(.DEPTH(CAPACITY), .WIDTH(EW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lpac_dist #(.CAPACITY(CAPACITY), .COORD_WIDTH(CW)) u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_accept && i_in_data.kind == KIND_DETECT),
        .i_radius      (r_radius),
        .i_v           (r_rd_v && r_state == S_SCAN),
        .i_idx         (r_rd_idx),
        .i_entry_label (w_rdata[OFS_LAB+7:OFS_LAB]),
        .i_mean_x      (w_rdata[CW-1:0]),
        .i_mean_y      (w_rdata[OFS_Y+CW-1:OFS_Y]),
        .i_label       (r_lab),
        .i_px          (r_px),
        .i_py          (r_py),
        .o_stat        (w_scan),
        .o_win         (w_win)
    );

    lpac_div #(.COORD_WIDTH(CW)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_DIV_GO),
        .i_mean_x (w_rdata[CW-1:0]),
        .i_mean_y (w_rdata[OFS_Y+CW-1:OFS_Y]),
        .i_mean_z (w_rdata[OFS_Z+CW-1:OFS_Z]),
        .i_pos_x  (r_px),
        .i_pos_y  (r_py),
        .i_pos_z  (r_pz),
        .i_hits   (w_hits),
        .o_q_x    (w_qx),
        .o_q_y    (w_qy),
        .o_q_z    (w_qz),
        .o_stat   (w_div)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_kind'(i_in_data.kind))
                        KIND_DETECT: n_state = S_SCAN;
                        KIND_TICK:   n_state = S_IDLE;
                        KIND_SWEEP:  n_state = S_SWEEP;
                        KIND_DUMP:   n_state = (r_used == '0) ? S_DUMP_OUT : S_DUMP_RD;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == r_used && !r_rd_v && !w_scan.busy) begin
                    n_state = w_scan.found ? S_WIN_RD : S_INS;
                end
            end
            S_WIN_RD:    n_state = S_DIV_GO;
            S_DIV_GO:    n_state = S_DIV;
            S_DIV:       if (w_div.done) n_state = S_UPD;
            S_UPD:       if (w_out_free) n_state = S_IDLE;
            S_INS:       if (w_out_free) n_state = S_IDLE;
            S_SWEEP:     if (r_idx == r_used && !r_rd_v) n_state = S_SWEEP_END;
            S_SWEEP_END: if (w_out_free) n_state = S_IDLE;
            S_DUMP_RD:   n_state = S_DUMP_OUT;
            S_DUMP_OUT: begin
                if (w_out_free) begin
                    n_state = (r_used == '0 || w_last_dump) ? S_IDLE : S_DUMP_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory control and result formation
    always_comb begin
        w_re        = 1'b0;
        w_raddr     = r_idx[AW-1:0];
        w_we        = 1'b0;
        w_waddr     = r_keep[AW-1:0];
        w_wdata     = w_rdata;
        w_emit      = 1'b0;
        w_emit_data = '0;
        unique case (r_state)
            S_SCAN, S_SWEEP: begin
                w_re = (r_idx < r_used);
                if (r_state == S_SWEEP && r_rd_v && !w_expired) begin
                    w_we = 1'b1;
                end
            end
            S_WIN_RD: begin
                w_re    = 1'b1;
                w_raddr = w_win;
            end
            S_DUMP_RD: begin
                w_re = 1'b1;
            end
            S_UPD: begin
                w_waddr = w_win;
                w_wdata[CW-1:0]                = w_qx;
                w_wdata[OFS_Y+CW-1:OFS_Y]      = w_qy;
                w_wdata[OFS_Z+CW-1:OFS_Z]      = w_qz;
                w_wdata[OFS_HIT+15:OFS_HIT]    = w_hits_new;
                w_wdata[OFS_STP+31:OFS_STP]    = r_tick;
                if (w_out_free) begin
                    w_we = 1'b1;
                    w_emit = 1'b1;
                end
                w_emit_data.status      = ST_MATCHED;
                w_emit_data.entry_id    = w_rdata[OFS_ID+31:OFS_ID];
                w_emit_data.entry_label = w_rdata[OFS_LAB+7:OFS_LAB];
                w_emit_data.mean_x      = f_out24(w_qx);
                w_emit_data.mean_y      = f_out24(w_qy);
                w_emit_data.mean_z      = f_out24(w_qz);
                w_emit_data.hit_count   = w_hits_new;
                w_emit_data.last        = 1'b1;
            end
            S_INS: begin
                w_waddr = r_used[AW-1:0];
                w_wdata = {r_tick, r_next_id, 16'd1, r_lab, r_pz, r_py, r_px};
                w_emit  = w_out_free;
                w_emit_data.last = 1'b1;
                if (r_used < UW'(CAPACITY)) begin
                    w_we = w_out_free;
                    w_emit_data.status      = ST_INSERTED;
                    w_emit_data.entry_id    = r_next_id;
                    w_emit_data.entry_label = r_lab;
                    w_emit_data.mean_x      = f_out24(r_px);
                    w_emit_data.mean_y      = f_out24(r_py);
                    w_emit_data.mean_z      = f_out24(r_pz);
                    w_emit_data.hit_count   = 16'd1;
                end else begin
                    w_emit_data.status = ST_DROPPED;
                end
            end
            S_SWEEP_END: begin
                w_emit = w_out_free;
                w_emit_data.status        = ST_SWEEP_DONE;
                w_emit_data.removed_count = 7'(r_removed);
                w_emit_data.last          = 1'b1;
            end
            S_DUMP_OUT: begin
                w_emit = w_out_free;
                if (r_used == '0) begin
                    w_emit_data.status = ST_DUMP_EMPTY;
                    w_emit_data.last   = 1'b1;
                end else begin
                    w_emit_data.status      = ST_DUMP_ENTRY;
                    w_emit_data.entry_id    = w_rdata[OFS_ID+31:OFS_ID];
                    w_emit_data.entry_label = w_rdata[OFS_LAB+7:OFS_LAB];
                    w_emit_data.mean_x      = f_out24(w_rdata[CW-1:0]);
                    w_emit_data.mean_y      = f_out24(w_rdata[OFS_Y+CW-1:OFS_Y]);
                    w_emit_data.mean_z      = f_out24(w_rdata[OFS_Z+CW-1:OFS_Z]);
                    w_emit_data.hit_count   = w_hits;
                    w_emit_data.last        = w_last_dump;
                end
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_tick      <= '0;
            r_next_id   <= '0;
            r_radius    <= 16'(REG_RADIUS_RESET);
            r_expiry    <= 16'(REG_EXPIRY_RESET);
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= w_re;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MATCH_RADIUS) r_radius <= i_cfg_data;
                if (i_cfg_idx == CFG_EXPIRY_TICKS) r_expiry <= i_cfg_data;
            end
            if (w_accept && i_in_data.kind == KIND_TICK) begin
                r_tick <= r_tick + 32'd1;
            end
            if (r_state == S_INS && w_we) begin
                r_used    <= r_used + UW'(1);
                r_next_id <= r_next_id + 32'd1;
            end
            if (r_state == S_SWEEP_END && w_emit) begin
                r_used <= r_keep;
            end
            // Hold a result until taken
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and scan registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= w_raddr;
        if (w_emit) begin
            r_out <= w_emit_data;
        end
        if (w_accept) begin
            r_lab     <= i_in_data.label;
            r_px      <= f_sat(i_in_data.pos_x);
            r_py      <= f_sat(i_in_data.pos_y);
            r_pz      <= f_sat(i_in_data.pos_z);
            r_idx     <= '0;
            r_keep    <= '0;
            r_removed <= '0;
        end else begin
            if ((r_state == S_SCAN || r_state == S_SWEEP) && w_re) begin
                r_idx <= r_idx + UW'(1);
            end
            if (r_state == S_DUMP_OUT && w_emit) begin
                r_idx <= r_idx + UW'(1);
            end
            if (r_state == S_SWEEP && r_rd_v) begin
                if (w_expired) r_removed <= r_removed + UW'(1);
                else           r_keep    <= r_keep + UW'(1);
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_UPD || r_state == S_INS || r_state == S_SWEEP))
        else $error("memory write outside an update state");

    a_sweep_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP_END && w_emit) |=> r_used <= $past(r_used))
        else $error("sweep grew the entry count");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && w_we) |-> (r_keep <= UW'(r_rd_idx)))
        else $error("sweep compaction wrote ahead of its read");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result loaded over a pending transaction");
`endif

endmodule

[rtl/lpac_mem.sv]
module lpac_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 160
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lpac_dist.sv]
module lpac_dist
    import lpac_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [15:0]                   i_radius,
    input  logic                          i_v,
    input  logic [$clog2(CAPACITY)-1:0]   i_idx,
    input  logic [7:0]                    i_entry_label,
    input  logic signed [COORD_WIDTH-1:0] i_mean_x,
    input  logic signed [COORD_WIDTH-1:0] i_mean_y,
    input  logic [7:0]                    i_label,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    output t_scan_stat                    o_stat,
    output logic [$clog2(CAPACITY)-1:0]   o_win
);

    localparam int AW = $clog2(CAPACITY);

    logic signed [33:0] w_dx, w_dy;
    logic [33:0]        w_ax, w_ay;
    logic               w_near;
    logic [32:0]        w_d2;
    logic [31:0]        w_r2;

    logic          r_s1_v, r_s2_v;
    logic [AW-1:0] r_s1_idx, r_s2_idx;
    logic [15:0]   r_s1_ax, r_s1_ay;
    logic [31:0]   r_s2_sx, r_s2_sy;
    logic [32:0]   r_best;
    logic [AW-1:0] r_win;
    logic          r_found;

    // Stage 1: absolute xy offsets and gating; also the stage 3 sum and the squared radius
    always_comb begin
        w_dx   = 34'(i_mean_x) - 34'(i_px);
        w_dy   = 34'(i_mean_y) - 34'(i_py);
        w_ax   = w_dx[33] ? 34'(-w_dx) : 34'(w_dx);
        w_ay   = w_dy[33] ? 34'(-w_dy) : 34'(w_dy);
        w_near = ~|w_ax[33:16] && ~|w_ay[33:16];
        w_d2   = 33'(r_s2_sx) + 33'(r_s2_sy);
        w_r2   = i_radius * i_radius;
    end

    // Stages 2 and 3: square, then sum and keep the closest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_s1_v <= i_v && (i_entry_label == i_label) && w_near;
            r_s2_v <= r_s1_v;
            if (i_start) begin
                r_found <= 1'b0;
            end else if (r_s2_v && (w_d2 < r_best)) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_idx;
        r_s1_ax  <= w_ax[15:0];
        r_s1_ay  <= w_ay[15:0];
        r_s2_idx <= r_s1_idx;
        r_s2_sx  <= r_s1_ax * r_s1_ax;
        r_s2_sy  <= r_s1_ay * r_s1_ay;
        if (i_start) begin
            r_best <= 33'(w_r2);
        end else if (r_s2_v && (w_d2 < r_best)) begin
            r_best <= w_d2;
            r_win  <= r_s2_idx;
        end
    end

    assign o_stat.busy  = r_s1_v || r_s2_v;
    assign o_stat.found = r_found;
    assign o_win        = r_win;

endmodule

[rtl/lpac_div.sv]
module lpac_div
    import lpac_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [COORD_WIDTH-1:0] i_mean_x,
    input  logic signed [COORD_WIDTH-1:0] i_mean_y,
    input  logic signed [COORD_WIDTH-1:0] i_mean_z,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic [15:0]                   i_hits,
    output logic signed [COORD_WIDTH-1:0] o_q_x,
    output logic signed [COORD_WIDTH-1:0] o_q_y,
    output logic signed [COORD_WIDTH-1:0] o_q_z,
    output t_div_stat                     o_stat
);

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = CW + 17;
    localparam int NW  = CW + 17;
    localparam int CNW = $clog2(CW + 1);

    t_div_ph r_ph, n_ph;
    logic [CNW-1:0] r_cnt;
    logic [16:0]    r_d;
    logic           r_done;

    logic signed [CW-1:0] w_m [3];
    logic signed [CW-1:0] w_p [3];
    logic signed [PW-1:0] r_prod [3];
    logic signed [CW-1:0] r_p [3];
    logic [NW-1:0]        r_num [3];
    logic [16:0]          r_rem [3];
    logic [CW-1:0]        r_q [3];
    logic                 r_neg [3];

    logic signed [CW+17:0] w_sum [3];
    logic [CW+17:0]        w_mag [3];
    logic [17:0]           w_sh [3];
    logic                  w_ge [3];
    logic signed [CW-1:0]  w_res [3];

    assign w_m[0] = i_mean_x;
    assign w_m[1] = i_mean_y;
    assign w_m[2] = i_mean_z;
    assign w_p[0] = i_pos_x;
    assign w_p[1] = i_pos_y;
    assign w_p[2] = i_pos_z;

    // Next phase
    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            DIV_IDLE: if (i_start) n_ph = DIV_PREP;
            DIV_PREP: n_ph = DIV_ITER;
            DIV_ITER: if (r_cnt == CNW'(CW - 1)) n_ph = DIV_IDLE;
            default:  n_ph = DIV_IDLE;
        endcase
    end

    // Lane datapath: numerator magnitude and one quotient bit a cycle
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_sum[l] = (CW + 18)'(r_prod[l]) + (CW + 18)'(r_p[l]);
            w_mag[l] = w_sum[l][CW+17] ? (CW + 18)'(-w_sum[l]) : (CW + 18)'(w_sum[l]);
            w_sh[l]  = {r_rem[l], r_num[l][CW-1]};
            w_ge[l]  = w_sh[l] >= {1'b0, r_d};
            w_res[l] = r_neg[l] ? CW'(-$signed(r_q[l])) : $signed(r_q[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= DIV_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph <= n_ph;
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_ph == DIV_ITER && n_ph == DIV_IDLE) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_ph)
            DIV_IDLE: begin
                r_d <= 17'(i_hits) + 17'd1;
                for (int l = 0; l < 3; l++) begin
                    r_prod[l] <= PW'(w_m[l]) * PW'($signed({1'b0, i_hits}));
                    r_p[l]    <= w_p[l];
                end
            end
            DIV_PREP: begin
                r_cnt <= '0;
                for (int l = 0; l < 3; l++) begin
                    r_neg[l] <= w_sum[l][CW+17];
                    r_num[l] <= w_mag[l][NW-1:0];
                    r_rem[l] <= w_mag[l][NW-1:CW];
                end
            end
            DIV_ITER: begin
                r_cnt <= r_cnt + CNW'(1);
                for (int l = 0; l < 3; l++) begin
                    r_rem[l] <= w_ge[l] ? 17'(w_sh[l] - {1'b0, r_d}) : w_sh[l][16:0];
                    r_q[l]   <= {r_q[l][CW-2:0], w_ge[l]};
                    r_num[l] <= {r_num[l][NW-2:0], 1'b0};
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_q_x       = w_res[0];
    assign o_q_y       = w_res[1];
    assign o_q_z       = w_res[2];
    assign o_stat.busy = (r_ph != DIV_IDLE);
    assign o_stat.done = r_done;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import lpac_pkg::*;

    localparam int NUM_SLOTS = 16;
    localparam int CYCLE_LIMIT = 1000000;

    // Behavioral copy of the association store; predicts results per transaction
    class assoc_scoreboard;
        logic signed [23:0] slot_x[NUM_SLOTS];
        logic signed [23:0] slot_y[NUM_SLOTS];
        logic signed [23:0] slot_z[NUM_SLOTS];
        logic [7:0]  slot_label[NUM_SLOTS];
        logic [15:0] slot_hits[NUM_SLOTS];
        logic [31:0] slot_id[NUM_SLOTS];
        logic [31:0] slot_stamp[NUM_SLOTS];
        int          used;
        logic [31:0] now_tick;
        logic [31:0] id_next;
        logic [15:0] radius;
        logic [15:0] expiry;
        t_out_item   pending[$];
        int          mismatches;

        function void clear_state();
            used = 0;
            now_tick = 0;
            id_next = 0;
            radius = 16'(REG_RADIUS_RESET);
            expiry = 16'(REG_EXPIRY_RESET);
            pending.delete();
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == CFG_MATCH_RADIUS) radius = val;
            else expiry = val;
        endfunction

        // Append an expected result behind those already waiting
        function void expect_result(t_out_item r);
            pending = {pending, r};
        endfunction

        function t_out_item slot_result(logic [2:0] st, int i);
            t_out_item r;
            r = '0;
            r.status = st;
            r.entry_id = slot_id[i];
            r.entry_label = slot_label[i];
            r.mean_x = slot_x[i];
            r.mean_y = slot_y[i];
            r.mean_z = slot_z[i];
            r.hit_count = slot_hits[i];
            return r;
        endfunction

        function logic signed [23:0] running_mean(logic signed [23:0] m,
                                                  logic signed [23:0] p,
                                                  logic [15:0] n);
            longint num;
            longint q;
            num = longint'(m) * longint'(n) + longint'(p);
            q = num / (longint'(n) + 1);
            return q[23:0];
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            int keep;
            int removed;
            int win;
            longint dx, dy;
            longint best, d2;
            case (t_kind'(it.kind))
                KIND_TICK: now_tick++;
                KIND_SWEEP: begin
                    keep = 0;
                    removed = 0;
                    for (int i = 0; i < used; i++) begin
                        if (now_tick - slot_stamp[i] > {16'd0, expiry}) begin
                            removed++;
                        end else begin
                            slot_x[keep] = slot_x[i];
                            slot_y[keep] = slot_y[i];
                            slot_z[keep] = slot_z[i];
                            slot_label[keep] = slot_label[i];
                            slot_hits[keep] = slot_hits[i];
                            slot_id[keep] = slot_id[i];
                            slot_stamp[keep] = slot_stamp[i];
                            keep++;
                        end
                    end
                    used = keep;
                    r = '0;
                    r.status = ST_SWEEP_DONE;
                    r.removed_count = removed[6:0];
                    r.last = 1'b1;
                    expect_result(r);
                end
                KIND_DUMP: begin
                    if (used == 0) begin
                        r = '0;
                        r.status = ST_DUMP_EMPTY;
                        r.last = 1'b1;
                        expect_result(r);
                    end
                    for (int i = 0; i < used; i++) begin
                        r = slot_result(ST_DUMP_ENTRY, i);
                        r.last = (i == used - 1);
                        expect_result(r);
                    end
                end
                default: begin
                    // Nearest same-label slot strictly inside the gate; first wins ties
                    best = longint'(radius) * longint'(radius);
                    win = -1;
                    for (int i = 0; i < used; i++) begin
                        if (slot_label[i] != it.label) continue;
                        dx = longint'(slot_x[i]) - longint'(it.pos_x);
                        dy = longint'(slot_y[i]) - longint'(it.pos_y);
                        if (dx < 0) dx = -dx;
                        if (dy < 0) dy = -dy;
                        if (dx >= 65536 || dy >= 65536) continue;
                        d2 = dx * dx + dy * dy;
                        if (d2 < best) begin
                            best = d2;
                            win = i;
                        end
                    end
                    if (win >= 0) begin
                        slot_x[win] = running_mean(slot_x[win], it.pos_x, slot_hits[win]);
                        slot_y[win] = running_mean(slot_y[win], it.pos_y, slot_hits[win]);
                        slot_z[win] = running_mean(slot_z[win], it.pos_z, slot_hits[win]);
                        if (slot_hits[win] != 16'hFFFF) slot_hits[win]++;
                        slot_stamp[win] = now_tick;
                        r = slot_result(ST_MATCHED, win);
                    end else if (used >= NUM_SLOTS) begin
                        r = '0;
                        r.status = ST_DROPPED;
                    end else begin
                        slot_x[used] = it.pos_x;
                        slot_y[used] = it.pos_y;
                        slot_z[used] = it.pos_z;
                        slot_label[used] = it.label;
                        slot_hits[used] = 1;
                        slot_id[used] = id_next;
                        slot_stamp[used] = now_tick;
                        id_next++;
                        r = slot_result(ST_INSERTED, used);
                        used++;
                    end
                    r.last = 1'b1;
                    expect_result(r);
                end
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = CFG_MATCH_RADIUS;
    logic [15:0] cfg_data = '0;

    assoc_scoreboard sb;
    int  cycle_count = 0;
    bit  allow_idle = 1'b1;
    int  hold_off = 0;
    int  stall_left = 0;

    labeled_point_association_cache dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Check results and note accepted transactions at the rising edge
    always @(posedge clk) begin
        cycle_count++;
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
        if (rst_n && in_valid && in_ready) sb.note_input(in_data);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Drive ready with random stall bursts, or a long hold-off
    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off--;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Offer one transaction; valid stays up until the next one or an idle stretch
    task automatic send_item(t_in_item it);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    function automatic t_in_item make_item(t_kind k, logic [7:0] lab,
                                           logic [23:0] x, logic [23:0] y, logic [23:0] z);
        t_in_item it;
        it.kind = k;
        it.label = lab;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        return it;
    endfunction

    // Random transaction: mostly detections, clustered near a few centers unless wide is set
    function automatic t_in_item random_item(int wide);
        int sel;
        logic [23:0] cx, cy;
        sel = $urandom_range(0, 99);
        if (sel < 8) return make_item(KIND_TICK, 0, 0, 0, 0);
        if (sel < 11) return make_item(KIND_SWEEP, 8'($urandom), 24'($urandom), 0, 0);
        if (sel < 14) return make_item(KIND_DUMP, 8'($urandom), 0, 24'($urandom), 0);
        if (wide != 0 || sel > 92)
            return make_item(KIND_DETECT, 8'($urandom), 24'($urandom), 24'($urandom),
                             24'($urandom));
        cx = 24'($urandom_range(0, 3)) * 24'd200 - 24'd300;
        cy = 24'($urandom_range(0, 2)) * 24'd150;
        return make_item(KIND_DETECT, 8'($urandom_range(0, 2)),
                         cx + 24'($urandom_range(0, 80)) - 24'd40,
                         cy + 24'($urandom_range(0, 80)) - 24'd40, 24'($urandom));
    endfunction

    initial begin
        sb = new();
        sb.clear_state();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty dump and sweep, extremes, full store
        send_item(make_item(KIND_DUMP, 0, 0, 0, 0));
        send_item(make_item(KIND_SWEEP, 0, 0, 0, 0));
        send_item(make_item(KIND_DETECT, 8'hFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        send_item(make_item(KIND_DETECT, 8'hFF, 24'h7FFFF0, 24'h7FFFF8, 24'h800000));
        send_item(make_item(KIND_DETECT, 8'h00, 24'h800000, 24'h800000, 24'h800000));
        send_item(make_item(KIND_DETECT, 8'h00, 24'h810000, 24'h800000, 24'h0));
        send_item(make_item(KIND_DETECT, 8'h01, 24'd0, 24'd0, 24'd0));
        send_item(make_item(KIND_DETECT, 8'h01, 24'd40, 24'd0, 24'd0));
        send_item(make_item(KIND_DETECT, 8'h01, 24'd20, 24'd0, 24'hFFFFFF));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0));
        send_item(make_item(KIND_DUMP, 0, 0, 0, 0));
        for (int i = 0; i < 14; i++)
            send_item(make_item(KIND_DETECT, 8'(i + 10), 24'(i), 24'(i), 24'(i)));
        wait_drain();

        write_reg(CFG_MATCH_RADIUS, 16'hFFFF);
        write_reg(CFG_EXPIRY_TICKS, 16'd0);
        send_item(make_item(KIND_DETECT, 8'h0A, 24'h00FFFF, 24'd0, 24'd0));
        send_item(make_item(KIND_TICK, 0, 0, 0, 0));
        send_item(make_item(KIND_SWEEP, 0, 0, 0, 0));
        wait_drain();

        // Receiver holds off while the sender keeps offering
        hold_off = 300;
        for (int i = 0; i < 30; i++) send_item(random_item(0));
        wait_drain();

        // Random phases with several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(CFG_MATCH_RADIUS, 16'd0); write_reg(CFG_EXPIRY_TICKS, 16'hFFFF); end
                1: begin write_reg(CFG_MATCH_RADIUS, 16'd64); write_reg(CFG_EXPIRY_TICKS, 16'd3); end
                2: begin write_reg(CFG_MATCH_RADIUS, 16'hFFFF); write_reg(CFG_EXPIRY_TICKS, 16'd10); end
                3: begin
                    write_reg(CFG_MATCH_RADIUS, 16'($urandom));
                    write_reg(CFG_EXPIRY_TICKS, 16'($urandom_range(0, 20)));
                end
                default: begin
                    write_reg(CFG_MATCH_RADIUS, 16'd100);
                    write_reg(CFG_EXPIRY_TICKS, 16'd5);
                    allow_idle = 1'b0;
                end
            endcase
            for (int i = 0; i < 80; i++) send_item(random_item(ph == 3 ? 1 : 0));
            wait_drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
